// File: src/wsfe_pkg.sv
package wsfe_pkg;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	localparam logic [1:0] CFG_FRAME_TYPE  = 2'd0;
	localparam logic [1:0] CFG_MASK_ENABLE = 2'd1;
	localparam logic [1:0] CFG_CAPACITY    = 2'd2;

	localparam logic [6:0]  FRAME_TYPE_RST = 7'd2;
	localparam logic [31:0] CAPACITY_RST   = 32'd65536;

	localparam logic [7:0]  FIN_BIT       = 8'h80;
	localparam logic [31:0] LEN_SHORT_MAX = 32'd125;
	localparam logic [31:0] LEN_MID_MAX   = 32'd65535;
	localparam logic [6:0]  CODE_LEN16    = 7'd126;
	localparam logic [6:0]  CODE_LEN64    = 7'd127;

	localparam logic [3:0] EXT_NONE = 4'd0;
	localparam logic [3:0] EXT_16   = 4'd2;
	localparam logic [3:0] EXT_64   = 4'd8;
	localparam logic [3:0] BASE_HDR = 4'd2;
	localparam logic [3:0] KEY_LEN  = 4'd4;

	typedef struct packed {
		logic        op;
		logic [31:0] payload_length;
		logic [7:0]  data_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
		logic       overflow;
	} out_t;

	// One queued job: a run of 1..14 bytes for the back end to emit.
	typedef struct packed {
		logic [3:0]  nbytes;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [31:0] len;
		logic [3:0]  ext;
		logic        fend;
		logic        ovf;
	} cmd_t;

	function automatic logic [7:0] mask_key(input logic [1:0] idx);
		logic [7:0] k;
		case (idx)
			2'd0: k = 8'ha0;
			2'd1: k = 8'hbc;
			2'd2: k = 8'h62;
			2'd3: k = 8'h9c;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

endpackage

// File: src/wsfe_front.sv
module wsfe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  wsfe_pkg::in_t      in_data,
	input  logic               q_full,
	output logic               in_stall,
	output logic               push,
	output wsfe_pkg::cmd_t     push_cmd
);

	logic [6:0]  frame_type_q;
	logic        mask_enable_q;
	logic [31:0] capacity_q;

	logic [31:0] bytes_left_q;
	logic [1:0]  key_index_q;
	logic        frame_open_q;

	logic        accept;
	logic [31:0] len;
	logic [3:0]  ext;
	logic [6:0]  code;
	logic [3:0]  hdr_n;
	logic [33:0] total;
	logic        too_big;
	logic [31:0] left_next;
	logic [7:0]  pay_byte;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign len      = in_data.payload_length;

	always_comb begin
		if (len <= wsfe_pkg::LEN_SHORT_MAX) begin
			ext  = wsfe_pkg::EXT_NONE;
			code = len[6:0];
		end else if (len <= wsfe_pkg::LEN_MID_MAX) begin
			ext  = wsfe_pkg::EXT_16;
			code = wsfe_pkg::CODE_LEN16;
		end else begin
			ext  = wsfe_pkg::EXT_64;
			code = wsfe_pkg::CODE_LEN64;
		end
		hdr_n   = wsfe_pkg::BASE_HDR + ext + (mask_enable_q ? wsfe_pkg::KEY_LEN : 4'd0);
		total   = {2'b00, len} + {30'd0, hdr_n};
		too_big = total > {2'b00, capacity_q};

		left_next = bytes_left_q - 32'd1;
		pay_byte  = in_data.data_byte ^
			(mask_enable_q ? wsfe_pkg::mask_key(key_index_q) : 8'h00);

		push_cmd = '0;
		push_cmd.len = len;
		push_cmd.ext = ext;
		if (in_data.op == wsfe_pkg::OP_START) begin
			if (too_big) begin
				push_cmd.nbytes = 4'd1;
				push_cmd.ovf    = 1'b1;
			end else begin
				push_cmd.nbytes = hdr_n;
				push_cmd.b0     = wsfe_pkg::FIN_BIT | {1'b0, frame_type_q};
				push_cmd.b1     = {mask_enable_q, code};
				push_cmd.fend   = (len == 32'd0);
			end
		end else begin
			push_cmd.nbytes = 4'd1;
			push_cmd.b0     = pay_byte;
			push_cmd.fend   = (left_next == 32'd0);
		end
		push = accept && (in_data.op == wsfe_pkg::OP_START || frame_open_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_type_q  <= wsfe_pkg::FRAME_TYPE_RST;
			mask_enable_q <= 1'b0;
			capacity_q    <= wsfe_pkg::CAPACITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wsfe_pkg::CFG_FRAME_TYPE:  frame_type_q  <= cfg_data[6:0];
				wsfe_pkg::CFG_MASK_ENABLE: mask_enable_q <= cfg_data[0];
				wsfe_pkg::CFG_CAPACITY:    capacity_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			key_index_q  <= '0;
			frame_open_q <= 1'b0;
		end else if (accept) begin
			if (in_data.op == wsfe_pkg::OP_START) begin
				key_index_q <= '0;
				if (too_big || len == 32'd0) begin
					frame_open_q <= 1'b0;
					bytes_left_q <= '0;
				end else begin
					frame_open_q <= 1'b1;
					bytes_left_q <= len;
				end
			end else if (frame_open_q) begin
				bytes_left_q <= left_next;
				if (left_next == 32'd0) begin
					frame_open_q <= 1'b0;
					key_index_q  <= '0;
				end else begin
					key_index_q <= key_index_q + 2'd1;
				end
			end
		end
	end

endmodule

// File: src/wsfe_queue.sv
module wsfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsfe_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output wsfe_pkg::cmd_t  head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsfe_pkg::cmd_t    slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slots_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/wsfe_back.sv
module wsfe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  wsfe_pkg::cmd_t  head_cmd,
	output logic            pop,
	input  logic            out_stall,
	output logic            out_valid,
	output wsfe_pkg::out_t  out_data
);

	logic [3:0] idx_q;
	logic       advance;
	logic       last;
	logic [3:0] pos;
	logic [3:0] ext_k;
	logic [1:0] len_sel;
	logic [7:0] ext_byte;
	logic [7:0] byte_sel;
	wsfe_pkg::out_t beat;

	assign advance = !out_valid || !out_stall;
	assign last    = (idx_q == head_cmd.nbytes - 4'd1);
	assign pop     = advance && head_valid && last;

	always_comb begin
		pos     = idx_q - wsfe_pkg::BASE_HDR;
		// position inside the 8-byte big-endian length field
		ext_k   = pos + (wsfe_pkg::EXT_64 - head_cmd.ext);
		len_sel = 2'(3'd7 - ext_k[2:0]);
		ext_byte = (ext_k < 4'd4) ? 8'h00 : head_cmd.len[8*len_sel +: 8];
		if (idx_q == 4'd0) begin
			byte_sel = head_cmd.b0;
		end else if (idx_q == 4'd1) begin
			byte_sel = head_cmd.b1;
		end else if (pos < head_cmd.ext) begin
			byte_sel = ext_byte;
		end else begin
			byte_sel = wsfe_pkg::mask_key(2'(pos - head_cmd.ext));
		end
		beat.out_byte  = byte_sel;
		beat.run_last  = last;
		beat.frame_end = last && head_cmd.fend;
		beat.overflow  = head_cmd.ovf;
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			out_data <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else if (advance) begin
			out_valid <= head_valid;
			if (head_valid) begin
				idx_q <= last ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

endmodule

// File: src/websocket_frame_encoder.sv
// Channel   Direction  Payload            Handshake
// cfg       in         cfg_index/data     cfg_we, no wait
// in        in         wsfe_pkg::in_t     in_valid / in_stall
// out       out        wsfe_pkg::out_t    out_valid / out_stall
//
// Front end takes one beat per cycle while the command queue has room; the
// header check (length code, capacity compare) and the payload XOR happen there.
// Back end emits one output beat per cycle while out_stall is low: a start beat
// expands to 2 to 14 bytes (1 on overflow), a payload beat to 1, so payload
// streams at one byte/cycle, a rate set by the back end's single output port.
// arst_n clears the queue, the frame state and the output valid; registers
// return to frame_type 2, mask off, capacity 65536.
// out_stall only holds the back end; the front keeps taking beats until the
// queue (QUEUE_DEPTH entries) fills, then raises in_stall.
module websocket_frame_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  wsfe_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output wsfe_pkg::out_t  out_data
);

	logic           q_full;
	logic           push;
	wsfe_pkg::cmd_t push_cmd;
	logic           pop;
	logic           head_valid;
	wsfe_pkg::cmd_t head_cmd;

	// accept, classify, keep frame state
	wsfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.q_full    (q_full),
		.in_stall  (in_stall),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// decouples the two sides
	wsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// expand each command into bytes, registered output
	wsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

	// the error beat stands alone and never closes a frame
	a_ovf_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |-> out_data.run_last && !out_data.frame_end)
		else $error("overflow beat not a lone run");

	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.run_last)
		else $error("frame_end without run_last");

	// a pop always comes from a non-empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// File: verif/tb_websocket_frame_encoder.sv
module tb_websocket_frame_encoder;

	localparam int CLK_PERIOD    = 12;
	// Worst drain: a full queue of 14-byte headers, plus margin.
	localparam int SETTLE_CYCLES = 80;
	// Accepted input beats before the random phases stop; the last phase
	// overshoots by a few dozen.
	localparam int BEAT_TARGET   = 330;
	localparam int LIMIT_CYCLES  = 600000;

	// Expected-byte store plus a private copy of the encoder state.
	class frame_scoreboard;
		logic [6:0]      frame_type;
		logic            mask_on;
		logic [31:0]     capacity;
		logic [31:0]     bytes_left;
		logic [1:0]      key_pos;
		logic            frame_open;
		logic [7:0]      key_bytes [4];
		wsfe_pkg::out_t  due_bytes [$];
		int              errors;
		int              beats_seen;

		function new();
			frame_type = 7'd2;
			mask_on    = 1'b0;
			capacity   = 32'd65536;
			bytes_left = '0;
			key_pos    = '0;
			frame_open = 1'b0;
			key_bytes  = '{8'ha0, 8'hbc, 8'h62, 8'h9c};
			errors     = 0;
			beats_seen = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				wsfe_pkg::CFG_FRAME_TYPE:  frame_type = value[6:0];
				wsfe_pkg::CFG_MASK_ENABLE: mask_on = value[0];
				wsfe_pkg::CFG_CAPACITY:    capacity = value;
				default: ;
			endcase
		endfunction

		function void queue_byte(logic [7:0] value, logic last, logic fend, logic ovf);
			wsfe_pkg::out_t r;
			r.out_byte  = value;
			r.run_last  = last;
			r.frame_end = fend;
			r.overflow  = ovf;
			due_bytes.push_back(r);
		endfunction

		// Works out every byte an accepted input beat should produce.
		function void note_beat(wsfe_pkg::in_t b);
			logic [7:0]      hdr [$];
			logic [6:0]      code;
			int              ext;
			longint unsigned total;
			logic [31:0]     len;
			logic            last;
			len = b.payload_length;
			beats_seen++;
			if (b.op == wsfe_pkg::OP_START) begin
				if (len <= wsfe_pkg::LEN_SHORT_MAX) begin
					code = len[6:0];
					ext  = 0;
				end else if (len <= wsfe_pkg::LEN_MID_MAX) begin
					code = wsfe_pkg::CODE_LEN16;
					ext  = 2;
				end else begin
					code = wsfe_pkg::CODE_LEN64;
					ext  = 8;
				end
				total = 64'd2 + 64'(ext) + (mask_on ? 64'd4 : 64'd0) + 64'(len);
				// any start drops whatever frame was still open
				frame_open = 1'b0;
				bytes_left = '0;
				key_pos    = '0;
				if (total > 64'(capacity)) begin
					queue_byte(8'h00, 1'b1, 1'b0, 1'b1);
					return;
				end
				hdr.push_back(wsfe_pkg::FIN_BIT | {1'b0, frame_type});
				hdr.push_back({mask_on, code});
				if (ext == 2) begin
					hdr.push_back(len[15:8]);
					hdr.push_back(len[7:0]);
				end else if (ext == 8) begin
					repeat (4) hdr.push_back(8'h00);
					hdr.push_back(len[31:24]);
					hdr.push_back(len[23:16]);
					hdr.push_back(len[15:8]);
					hdr.push_back(len[7:0]);
				end
				if (mask_on) begin
					foreach (key_bytes[k]) hdr.push_back(key_bytes[k]);
				end
				foreach (hdr[i]) begin
					last = (i == hdr.size() - 1);
					queue_byte(hdr[i], last, last && (len == 0), 1'b0);
				end
				if (len != 0) begin
					frame_open = 1'b1;
					bytes_left = len;
				end
			end else if (frame_open) begin
				queue_byte(b.data_byte ^ (mask_on ? key_bytes[key_pos] : 8'h00), 1'b1,
					bytes_left == 1, 1'b0);
				key_pos++;
				bytes_left--;
				if (bytes_left == 0) begin
					frame_open = 1'b0;
					key_pos    = '0;
				end
			end
		endfunction

		function void check_beat(wsfe_pkg::out_t got);
			wsfe_pkg::out_t want;
			if (due_bytes.size() == 0) begin
				$error("out_byte: expected nothing, got %02h", got.out_byte);
				errors++;
				return;
			end
			want = due_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %b, got %b", want.overflow, got.overflow);
				errors++;
			end
		endfunction

		function int pending();
			return due_bytes.size();
		endfunction
	endclass

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cfg_we    = 1'b0;
	logic [1:0]     cfg_index = wsfe_pkg::CFG_FRAME_TYPE;
	logic [31:0]    cfg_data  = '0;
	logic           in_valid  = 1'b0;
	logic           in_stall;
	wsfe_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	wsfe_pkg::out_t out_data;

	// Idling switch: while calm is set neither side inserts gaps.
	bit              calm = 1'b0;
	frame_scoreboard sb;

	websocket_frame_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Receiver back-pressure, about a third of the cycles.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 34);
	end

	// Everything is sampled at the edge, so all values seen here are the
	// pre-edge ones. Register writes, input beats and output beats are
	// applied to the scoreboard in that order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.set_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall) sb.note_beat(in_data);
			if (out_valid && !out_stall) sb.check_beat(out_data);
		end
	end

	function automatic wsfe_pkg::in_t mk_start(logic [31:0] len);
		wsfe_pkg::in_t b;
		b.op             = wsfe_pkg::OP_START;
		b.payload_length = len;
		b.data_byte      = 8'($urandom());
		return b;
	endfunction

	// Unused length field gets noise so every bit toggles on both ops.
	function automatic wsfe_pkg::in_t mk_payload(logic [7:0] value);
		wsfe_pkg::in_t b;
		b.op             = wsfe_pkg::OP_PAYLOAD;
		b.payload_length = $urandom();
		b.data_byte      = value;
		return b;
	endfunction

	// Valid stays high from one beat to the next unless a gap is rolled,
	// so it is never dropped and raised in the same step.
	task automatic send_beat(input wsfe_pkg::in_t beat);
		while (!calm && ($urandom_range(99) < 34)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Wait for every expected byte, then idle for SETTLE_CYCLES; stray payload
	// bytes are never queued and make no output.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(logic [6:0] ftype, logic menable, logic [31:0] cap);
		cfg_we    <= 1'b1;
		cfg_index <= wsfe_pkg::CFG_FRAME_TYPE;
		cfg_data  <= {25'd0, ftype};
		@(posedge clk);
		cfg_index <= wsfe_pkg::CFG_MASK_ENABLE;
		cfg_data  <= {31'd0, menable};
		@(posedge clk);
		cfg_index <= wsfe_pkg::CFG_CAPACITY;
		cfg_data  <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One frame, mostly well formed. Some are cut short (next start
	// abandons them), some have a stray trailing byte, some are pure noise.
	task automatic random_frame();
		int unsigned pick;
		int unsigned len;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 3)) send_beat(mk_payload(8'($urandom())));
			return;
		end
		if (pick < 60) len = $urandom_range(0, 12);
		else if (pick < 75) len = $urandom_range(13, 140);
		else if (pick < 85) len = $urandom();
		else begin
			case ($urandom_range(5))
				0: len = 125;
				1: len = 126;
				2: len = 65535;
				3: len = 65536;
				4: len = 127;
				default: len = 32'hffff_ffff;
			endcase
		end
		send_beat(mk_start(len));
		if (len <= 12 && $urandom_range(9) != 0)
			n = len + (($urandom_range(3) == 0) ? 1 : 0);
		else
			n = $urandom_range(0, 6);
		// now and then carry a longer frame all the way to its end
		if (len <= 140 && $urandom_range(29) == 0) n = len;
		repeat (n) send_beat(mk_payload(8'($urandom())));
	endtask

	initial begin
		int          phase;
		logic [6:0]  ftype;
		logic        menable;
		logic [31:0] cap;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, reset register values: stray byte with no frame, empty
		// payload, a short complete frame, length-code edges, and two frames
		// that miss the default capacity by their extended headers alone.
		send_beat(mk_payload(8'h5a));
		send_beat(mk_start(32'd0));
		send_beat(mk_start(32'd3));
		send_beat(mk_payload(8'h00));
		send_beat(mk_payload(8'hff));
		send_beat(mk_payload(8'h5a));
		send_beat(mk_start(32'd125));
		send_beat(mk_payload(8'ha5));
		send_beat(mk_start(32'd126));
		send_beat(mk_start(32'd65535));
		send_beat(mk_start(32'd65536));
		settle();

		// Masking on, widest type and capacity: the 14-byte header, key
		// wrap inside a frame, then a mask switch partway through one.
		load_regs(7'd127, 1'b1, 32'hffff_ffff);
		send_beat(mk_start(32'hffff_ff00));
		send_beat(mk_start(32'd5));
		repeat (5) send_beat(mk_payload(8'($urandom())));
		send_beat(mk_start(32'd4));
		send_beat(mk_payload(8'hff));
		send_beat(mk_payload(8'h00));
		settle();
		load_regs(7'd127, 1'b0, 32'hffff_ffff);
		send_beat(mk_payload(8'h81));
		send_beat(mk_payload(8'h7e));
		settle();

		// Capacity boundary: exactly full passes, one more byte overflows
		// and the payload after it is dropped; zero capacity rejects all.
		load_regs(7'd0, 1'b0, 32'd12);
		send_beat(mk_start(32'd10));
		send_beat(mk_start(32'd11));
		send_beat(mk_payload(8'h33));
		settle();
		load_regs(7'd0, 1'b0, 32'd0);
		send_beat(mk_start(32'd0));
		settle();

		// Random phases, each with its own register setting. A frame left
		// open at a phase end sees the next setting mid-frame.
		phase = 0;
		while (sb.beats_seen < BEAT_TARGET) begin
			ftype   = 7'($urandom());
			menable = 1'($urandom());
			case (phase % 5)
				0: begin
					ftype   = 7'd127;
					menable = 1'b1;
					cap     = 32'hffff_ffff;
				end
				1: begin
					ftype = 7'd0;
					cap   = $urandom_range(2, 40);
				end
				2: cap = wsfe_pkg::CAPACITY_RST;
				3: cap = $urandom();
				default: cap = ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(14, 200);
			endcase
			// one long phase without any gaps on either side
			calm = (phase == 2);
			load_regs(ftype, menable, cap);
			repeat ($urandom_range(6, 12)) random_frame();
			settle();
			phase++;
		end
		calm = 1'b0;

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
src/wsfe_pkg.sv
src/wsfe_front.sv
src/wsfe_queue.sv
src/wsfe_back.sv
src/websocket_frame_encoder.sv
verif/tb_websocket_frame_encoder.sv
